>>> src/lcs_pkg.sv
// shared types and constants for the lcs length engine
`default_nettype none

package lcs_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 64;
   localparam int unsigned LEN_W = 7;
   localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_END   = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0] lcs_length;
      logic             overflowed;
   } rsp_payload_type;

   // transaction token moving down the cell chain
   typedef struct packed {
      logic         vld;
      req_code_type kind;
      logic [7:0]   symbol;
   } tok_ctl_type;

endpackage

`default_nettype wire

>>> src/lcs_cell.sv
// one cell of the chain: holds one reference symbol and its score
`default_nettype none

module lcs_cell #(
   parameter int unsigned SCORE_W = 7
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  wire lcs_pkg::tok_ctl_type ctl_i,
   input  wire  [SCORE_W-1:0]       left_i,
   input  wire  [SCORE_W-1:0]       diag_i,
   input  wire  [SCORE_W-1:0]       res_i,
   output lcs_pkg::tok_ctl_type     ctl_o,
   output logic [SCORE_W-1:0]       left_o,
   output logic [SCORE_W-1:0]       diag_o,
   output logic [SCORE_W-1:0]       res_o
);
   import lcs_pkg::*;

   logic               loaded_ff, loaded_in;
   logic [7:0]         ref_ff, ref_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   tok_ctl_type        ctl_ff, ctl_in;
   logic [SCORE_W-1:0] left_ff, left_in;
   logic [SCORE_W-1:0] diag_ff, diag_in;
   logic [SCORE_W-1:0] res_ff, res_in;

   always_comb begin
      ctl_in    = ctl_i;
      left_in   = '0;
      diag_in   = '0;
      res_in    = res_i;
      loaded_in = loaded_ff;
      ref_in    = ref_ff;
      score_in  = score_ff;
      if (ctl_i.vld) begin
         unique case (ctl_i.kind)
            REQ_QUERY: begin
               if (loaded_ff) begin
                  if (ref_ff == ctl_i.symbol) begin
                     score_in = diag_i + SCORE_W'(1);
                  end else begin
                     score_in = (score_ff > left_i) ? score_ff : left_i;
                  end
                  left_in = score_in;
                  diag_in = score_ff;
               end
            end
            REQ_LOAD: begin
               // first free cell takes the symbol and retires the transaction
               if (!loaded_ff) begin
                  loaded_in  = 1'b1;
                  ref_in     = ctl_i.symbol;
                  score_in   = '0;
                  ctl_in.vld = 1'b0;
               end
            end
            REQ_END: begin
               if (loaded_ff) begin
                  res_in    = score_ff;
                  loaded_in = 1'b0;
                  score_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         score_ff  <= '0;
         ctl_ff    <= '0;
      end else if (advance) begin
         loaded_ff <= loaded_in;
         score_ff  <= score_in;
         ctl_ff    <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ref_ff  <= ref_in;
         left_ff <= left_in;
         diag_ff <= diag_in;
         res_ff  <= res_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign left_o = left_ff;
   assign diag_o = diag_ff;
   assign res_o  = res_ff;

endmodule

`default_nettype wire

>>> src/lcs_length_engine.sv
// lcs length engine: a transaction enters a chain of MAX_LEN cells, one cell per cycle
// while the chain advances, followed by one output register that holds an end result.
// one transaction is accepted every cycle while req_stall is low; depth of the cell chain
// sets the latency. a waiting result holds the chain and raises req_stall only once the
// next end transaction reaches the tail, and only until the waiting result is taken.
// reset empties the reference, zeroes all scores and the overflow flag, drops any result.
`default_nettype none

module lcs_length_engine #(
   parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  lcs_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output lcs_pkg::rsp_payload_type     rsp_data
);
   import lcs_pkg::*;

   localparam int unsigned SCORE_W = $clog2(MAX_LEN + 1);
   localparam int unsigned EXT_W   = (SCORE_W > LEN_W) ? SCORE_W : LEN_W;

   tok_ctl_type        ctl_chain  [0:MAX_LEN];
   logic [SCORE_W-1:0] left_chain [0:MAX_LEN];
   logic [SCORE_W-1:0] diag_chain [0:MAX_LEN];
   logic [SCORE_W-1:0] res_chain  [0:MAX_LEN];

   logic            advance;
   tok_ctl_type     tail;
   logic            ovf_ff, ovf_in;
   logic            out_vld_ff, out_vld_in;
   rsp_payload_type out_ff, out_in;
   logic [EXT_W-1:0] res_ext;

   // unused request code never enters the chain
   assign ctl_chain[0] = '{
      vld:    req_valid && ((req_data.req_type == REQ_LOAD) ||
                            (req_data.req_type == REQ_QUERY) ||
                            (req_data.req_type == REQ_END)),
      kind:   req_code_type'(req_data.req_type),
      symbol: req_data.symbol
   };
   assign left_chain[0] = '0;
   assign diag_chain[0] = '0;
   assign res_chain[0]  = '0;

   for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
      lcs_cell #(.SCORE_W(SCORE_W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .ctl_i  (ctl_chain[j]),
         .left_i (left_chain[j]),
         .diag_i (diag_chain[j]),
         .res_i  (res_chain[j]),
         .ctl_o  (ctl_chain[j+1]),
         .left_o (left_chain[j+1]),
         .diag_o (diag_chain[j+1]),
         .res_o  (res_chain[j+1])
      );
   end

   assign tail    = ctl_chain[MAX_LEN];
   assign res_ext = EXT_W'(res_chain[MAX_LEN]);

   always_comb begin
      advance    = !(tail.vld && (tail.kind == REQ_END) && out_vld_ff && rsp_stall);
      ovf_in     = ovf_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      out_in     = out_ff;
      if (advance && tail.vld) begin
         unique case (tail.kind)
            REQ_LOAD: begin
               // a load that found no free cell
               ovf_in = 1'b1;
            end
            REQ_END: begin
               out_vld_in        = 1'b1;
               out_in.lcs_length = (res_ext > EXT_W'(LEN_SAT)) ? LEN_SAT : res_ext[LEN_W-1:0];
               out_in.overflowed = ovf_ff;
               ovf_in            = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         ovf_ff     <= ovf_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign req_stall = !advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
